### rtl/mvt_pkg.sv
// Shared types and constants for the 4x4 matrix vector transform.
package mvt_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int DATA_WIDTH        = 32;
   localparam int NUM_COLS          = 4;
   localparam int NUM_REGS          = 8;
   localparam int REG_WIDTH         = 64;
   localparam int REG_IDX_WIDTH     = $clog2(NUM_REGS);
   localparam int CSR_BYTE_BITS     = 3;
   localparam int CSR_ADDR_WIDTH    = REG_IDX_WIDTH + CSR_BYTE_BITS;
   localparam int PROD_WIDTH        = 2 * DATA_WIDTH;
   localparam int PAIR_WIDTH        = PROD_WIDTH + 1;
   localparam int SUM_WIDTH         = PROD_WIDTH + 2;
   localparam int PIPE_STAGES       = 5;

   // Coefficient register indexes
   typedef enum int {
      ROW0_COLS01, ROW0_COLS23, ROW1_COLS01, ROW1_COLS23,
      ROW2_COLS01, ROW2_COLS23, ROW3_COLS01, ROW3_COLS23
   } coef_reg_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] vec_x;
      logic signed [DATA_WIDTH-1:0] vec_y;
      logic signed [DATA_WIDTH-1:0] vec_z;
      logic signed [DATA_WIDTH-1:0] vec_w;
      logic                         point3;
   } vec_in_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] out_x;
      logic signed [DATA_WIDTH-1:0] out_y;
      logic signed [DATA_WIDTH-1:0] out_z;
      logic signed [DATA_WIDTH-1:0] out_w;
   } vec_out_type;

   typedef logic [NUM_REGS-1:0][REG_WIDTH-1:0]   coef_regs_type;
   typedef logic [NUM_COLS-1:0][DATA_WIDTH-1:0]  lane_vec_type;

   // Identity matrix: 1.0 on the diagonal, low half for even rows, high half for odd.
   function automatic coef_regs_type identity_regs(input int frac_bits);
      coef_regs_type regs;
      logic [REG_WIDTH-1:0] one_lo;
      logic [REG_WIDTH-1:0] one_hi;
      one_lo  = REG_WIDTH'(1) << frac_bits;
      one_hi  = REG_WIDTH'(1) << (frac_bits + DATA_WIDTH);
      regs    = '0;
      regs[ROW0_COLS01] = one_lo;
      regs[ROW1_COLS01] = one_hi;
      regs[ROW2_COLS23] = one_lo;
      regs[ROW3_COLS23] = one_hi;
      return regs;
   endfunction

endpackage

### rtl/mvt_csr.sv
// Coefficient register file behind the APB-style configuration port.
module mvt_csr #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [mvt_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [mvt_pkg::REG_WIDTH-1:0]        csr_pwdata,
   output logic [mvt_pkg::REG_WIDTH-1:0]        csr_prdata,
   output mvt_pkg::coef_regs_type               coef_regs
);

   mvt_pkg::coef_regs_type                regs_ff;
   mvt_pkg::coef_regs_type                regs_in;
   logic [mvt_pkg::REG_IDX_WIDTH-1:0]     reg_idx;
   logic                                  wr_en;

   assign reg_idx = csr_paddr[mvt_pkg::CSR_ADDR_WIDTH-1:mvt_pkg::CSR_BYTE_BITS];
   assign wr_en   = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         regs_in[reg_idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= mvt_pkg::identity_regs(FRAC_BITS);
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_prdata = regs_ff[reg_idx];
   assign coef_regs  = regs_ff;

endmodule

### rtl/mvt_dot_row.sv
// One matrix row: four multiplies, adder tree, rounding and saturation, four stages.
module mvt_dot_row #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  enable,
   input  mvt_pkg::lane_vec_type                 vec,
   input  mvt_pkg::lane_vec_type                 coef,
   output logic signed [mvt_pkg::DATA_WIDTH-1:0] dot
);

   localparam int PW = mvt_pkg::PROD_WIDTH;
   localparam int AW = mvt_pkg::PAIR_WIDTH;
   localparam int SW = mvt_pkg::SUM_WIDTH;
   localparam int DW = mvt_pkg::DATA_WIDTH;
   localparam logic signed [SW-1:0] Half   = SW'(1) <<< (FRAC_BITS - 1);
   localparam logic signed [SW-1:0] SatMax = SW'({1'b0, {(DW-1){1'b1}}});
   localparam logic signed [SW-1:0] SatMin = -SatMax - SW'(1);

   logic signed [PW-1:0] prod_ff [mvt_pkg::NUM_COLS];
   logic signed [PW-1:0] prod_in [mvt_pkg::NUM_COLS];
   logic signed [AW-1:0] pair_ff [2];
   logic signed [AW-1:0] pair_in [2];
   logic signed [SW-1:0] sum_ff;
   logic signed [SW-1:0] sum_in;
   logic signed [SW-1:0] shifted;
   logic signed [DW-1:0] dot_ff;
   logic signed [DW-1:0] dot_in;

   always_comb begin
      for (int c = 0; c < mvt_pkg::NUM_COLS; c++) begin
         prod_in[c] = PW'($signed(coef[c])) * PW'($signed(vec[c]));
      end
      pair_in[0] = AW'(prod_ff[0]) + AW'(prod_ff[1]);
      pair_in[1] = AW'(prod_ff[2]) + AW'(prod_ff[3]);
      // exact sum plus half an LSB of the result; the shift then floors
      sum_in     = SW'(pair_ff[0]) + SW'(pair_ff[1]) + Half;
      shifted    = sum_ff >>> FRAC_BITS;
      if (shifted > SatMax) begin
         dot_in = SatMax[DW-1:0];
      end else if (shifted < SatMin) begin
         dot_in = SatMin[DW-1:0];
      end else begin
         dot_in = shifted[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= prod_in;
         pair_ff <= pair_in;
         sum_ff  <= sum_in;
         dot_ff  <= dot_in;
      end
   end

   assign dot = dot_ff;

endmodule

### rtl/matrix4_vector_transform.sv
// Pipeline: an accepted input transfer passes 5 register stages (the input register being
//   the first) before rsp_valid rises with its result.
// Throughput: one vector per cycle; the whole five-stage pipeline (input register,
//   multiply, pair add, round add, saturate) advances together unless a held result is stalled.
// Reset (synchronous, active high) empties the pipeline and loads the identity matrix.
// Coefficient writes are registered at the end of the access phase; pready is always high.
module matrix4_vector_transform #(
   parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  mvt_pkg::vec_in_type                req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output mvt_pkg::vec_out_type               rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [mvt_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [mvt_pkg::REG_WIDTH-1:0]      csr_pwdata,
   output logic [mvt_pkg::REG_WIDTH-1:0]      csr_prdata,
   output logic                               csr_pready
);

   localparam int DW = mvt_pkg::DATA_WIDTH;

   mvt_pkg::coef_regs_type              coef_regs;
   mvt_pkg::lane_vec_type               vec_ff;
   mvt_pkg::lane_vec_type               vec_in;
   mvt_pkg::lane_vec_type               row_coef [mvt_pkg::NUM_COLS];
   logic signed [DW-1:0]                row_dot  [mvt_pkg::NUM_COLS];
   logic [mvt_pkg::PIPE_STAGES-1:0]     valid_ff;
   logic [mvt_pkg::PIPE_STAGES-1:0]     valid_in;
   logic                                enable;
   logic                                accept;

   mvt_csr #(.FRAC_BITS(FRAC_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .coef_regs   (coef_regs)
   );

   assign csr_pready = 1'b1;

   // pipeline moves whenever the output register is empty or being taken
   assign enable    = !valid_ff[mvt_pkg::PIPE_STAGES-1] || !rsp_stall;
   assign req_stall = !enable;
   assign accept    = req_valid && enable;

   always_comb begin
      vec_in[0] = req_data.vec_x;
      vec_in[1] = req_data.vec_y;
      vec_in[2] = req_data.vec_z;
      vec_in[3] = req_data.point3 ? (DW'(1) << FRAC_BITS) : req_data.vec_w;
      valid_in  = {valid_ff[mvt_pkg::PIPE_STAGES-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         vec_ff <= vec_in;
      end
   end

   for (genvar r = 0; r < mvt_pkg::NUM_COLS; r++) begin : g_row
      // row r: register 2r holds columns 0 and 1, register 2r+1 columns 2 and 3
      assign row_coef[r][0] = coef_regs[2*r][DW-1:0];
      assign row_coef[r][1] = coef_regs[2*r][2*DW-1:DW];
      assign row_coef[r][2] = coef_regs[2*r+1][DW-1:0];
      assign row_coef[r][3] = coef_regs[2*r+1][2*DW-1:DW];

      mvt_dot_row #(.FRAC_BITS(FRAC_BITS)) u_row (
         .clock  (clock),
         .enable (enable),
         .vec    (vec_ff),
         .coef   (row_coef[r]),
         .dot    (row_dot[r])
      );
   end

   assign rsp_valid      = valid_ff[mvt_pkg::PIPE_STAGES-1];
   assign rsp_data.out_x = row_dot[0];
   assign rsp_data.out_y = row_dot[1];
   assign rsp_data.out_z = row_dot[2];
   assign rsp_data.out_w = row_dot[3];

   a_reset_empties: assert property (@(posedge clock) reset |=> valid_ff == '0)
      else $error("pipeline not empty after reset");

   a_idle_out_accepts: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output register is empty");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> valid_ff == $past(valid_ff))
      else $error("pipeline moved during output stall");

   a_last_stage_lands: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[mvt_pkg::PIPE_STAGES-2] && enable) |=> rsp_valid)
      else $error("item lost between last stages");

endmodule
